// File: hw/rtl/sfdt_pkg.sv
// package for the shared face dedup table: sizes, codes, entry layout
// and the face match function; used by every file of the block but sfdt_ram
`timescale 1ns / 1ps

package sfdt_pkg;

  localparam int POINT_SLOTS = 4096;
  localparam int ENTRY_SLOTS = 4096;

  localparam int ID_W    = 12;
  localparam int ACT_W   = 13;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 3;
  localparam int HEAD_AW = $clog2(POINT_SLOTS);
  localparam int ENT_AW  = $clog2(ENTRY_SLOTS);
  localparam int LINK_W  = ENT_AW + 1;
  localparam int N_W     = HEAD_AW + 1;
  localparam int CMP_W   = ((ID_W > HEAD_AW) ? ID_W : HEAD_AW) + 1;

  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(ENTRY_SLOTS);
  localparam logic [ACT_W-1:0]  ACT_RESET = ACT_W'(4096);

  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUAD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRI     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FETCH   = 3'd4;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_MATCHED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FACE     = 3'd4;
  localparam logic [STAT_W-1:0] ST_END      = 3'd5;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd6;

  localparam logic [2:0] ADDR_ACTIVE = 3'd0;

  typedef struct packed {
    logic [ID_W-1:0] p0;
    logic [ID_W-1:0] p1;
    logic [ID_W-1:0] p2;
    logic [ID_W-1:0] p3;
  } face_t;

  typedef struct packed {
    face_t             face;
    logic              hidden;
    logic [LINK_W-1:0] next;
  } entry_t;

  typedef struct packed {
    face_t face;
    logic  bad;
  } canon_t;

  localparam int ENTRY_W = $bits(entry_t);

  // leading ids are equal by bucket, so p0 is not compared
  function automatic logic face_match(face_t f, entry_t e, logic is_tri);
    logic hit;
    if (is_tri) begin
      hit = (e.face.p0 == e.face.p3) &&
            ((f.p1 == e.face.p1 && f.p2 == e.face.p2) ||
             (f.p1 == e.face.p2 && f.p2 == e.face.p1));
    end else begin
      hit = (f.p2 == e.face.p2) &&
            ((f.p1 == e.face.p1 && f.p3 == e.face.p3) ||
             (f.p1 == e.face.p3 && f.p3 == e.face.p1));
    end
    return hit;
  endfunction

endpackage

// File: hw/rtl/sfdt_if.sv
// channel interfaces of the shared face dedup table
// depends on sfdt_pkg
`timescale 1ns / 1ps

interface sfdt_in_if;
  import sfdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   pt_a;
  logic [ID_W-1:0]   pt_b;
  logic [ID_W-1:0]   pt_c;
  logic [ID_W-1:0]   pt_d;
  modport source (output valid, kind, pt_a, pt_b, pt_c, pt_d, input ready);
  modport sink (input valid, kind, pt_a, pt_b, pt_c, pt_d, output ready);
endinterface

interface sfdt_out_if;
  import sfdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   face_p0;
  logic [ID_W-1:0]   face_p1;
  logic [ID_W-1:0]   face_p2;
  logic [ID_W-1:0]   face_p3;
  modport source (output valid, status, face_p0, face_p1, face_p2, face_p3, input ready);
  modport sink (input valid, status, face_p0, face_p1, face_p2, face_p3, output ready);
endinterface

// File: hw/rtl/sfdt_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module sfdt_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/sfdt_canon.sv
// rotates an incoming face so a strictly smallest id leads and checks id range
// depends on sfdt_pkg
`timescale 1ns / 1ps

module sfdt_canon
  import sfdt_pkg::*;
(
  input  logic            is_tri,
  input  logic [ID_W-1:0] a,
  input  logic [ID_W-1:0] b,
  input  logic [ID_W-1:0] c,
  input  logic [ID_W-1:0] d,
  input  logic [N_W-1:0]  n,
  output canon_t          canon
);

  logic [CMP_W-1:0] nw;

  assign nw = CMP_W'(n);

  always_comb begin
    canon.face = '{p0: a, p1: b, p2: c, p3: d};
    if (is_tri) begin
      // strict compares: ties keep the id order as it is
      if (b < a && b < c) begin
        canon.face = '{p0: b, p1: c, p2: a, p3: b};
      end else if (c < a && c < b) begin
        canon.face = '{p0: c, p1: a, p2: b, p3: c};
      end else begin
        canon.face = '{p0: a, p1: b, p2: c, p3: a};
      end
      canon.bad = (CMP_W'(a) >= nw) || (CMP_W'(b) >= nw) || (CMP_W'(c) >= nw);
    end else begin
      if (b < a && b < c && b < d) begin
        canon.face = '{p0: b, p1: c, p2: d, p3: a};
      end else if (c < a && c < b && c < d) begin
        canon.face = '{p0: c, p1: d, p2: a, p3: b};
      end else if (d < a && d < b && d < c) begin
        canon.face = '{p0: d, p1: a, p2: b, p3: c};
      end
      canon.bad = (CMP_W'(a) >= nw) || (CMP_W'(b) >= nw) ||
                  (CMP_W'(c) >= nw) || (CMP_W'(d) >= nw);
    end
  end

endmodule

// File: hw/rtl/shared_face_dedup_table.sv
// top level of the shared face dedup table: sequencer, bucket head and
// entry memories, config register; depends on sfdt_pkg, sfdt_if,
// sfdt_ram and sfdt_canon
`timescale 1ns / 1ps

// channel  | dir | transfer when      | payload
// in_ch    | in  | valid && ready     | kind, pt_a, pt_b, pt_c, pt_d
// out_ch   | out | valid && ready     | status, face_p0..face_p3
// apb      | in  | psel&penable&pwrite| active_points at address 0
//
// one item at a time; an insert reads the bucket head, then walks the bucket's
// entries until one matches or the chain ends, else appends a new entry and
// links it from the head or from the last entry; a fetch walks entries and
// buckets in turn; restart reads the head of bucket 0; a range error or an
// unknown kind goes straight to the finish step. each step of a walk waits on
// the registered read of the head or entry memory. clear is a sweep of the head memory.
// after reset the same head sweep runs, with in_ch.ready low.
// a finished result sits in the output register, so the next item is taken
// while it waits; only the finish of that next item stalls on out_ch.ready.

module shared_face_dedup_table
  import sfdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  sfdt_in_if.sink      in_ch,
  sfdt_out_if.source   out_ch
);

  typedef enum logic [10:0] {
    S_CLR    = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_HWAIT  = 11'b000_0000_0100,
    S_EWAIT  = 11'b000_0000_1000,
    S_APPEND = 11'b000_0001_0000,
    S_LINK   = 11'b000_0010_0000,
    S_RSWAIT = 11'b000_0100_0000,
    S_FCHK   = 11'b000_1000_0000,
    S_FHWAIT = 11'b001_0000_0000,
    S_FWAIT  = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  state_t              state;
  logic [ACT_W-1:0]    active;
  logic [N_W-1:0]      n;
  logic                tri_q;
  face_t               face_q;
  logic [LINK_W-1:0]   cur;
  logic [LINK_W-1:0]   last;
  entry_t              last_rec;
  logic [LINK_W-1:0]   used;
  logic [N_W-1:0]      walk_bucket;
  logic [N_W-1:0]      nb;
  logic [LINK_W-1:0]   walk_entry;
  logic [HEAD_AW-1:0]  clr_cnt;
  logic                clr_emit;
  logic [STAT_W-1:0]   res_status;
  face_t               res_face;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  face_t               out_face;

  canon_t              canon;
  logic                in_tri;
  logic                in_xfer;
  logic                used_full;
  logic                hit;

  logic                head_we;
  logic [HEAD_AW-1:0]  head_waddr;
  logic [LINK_W-1:0]   head_wdata;
  logic [HEAD_AW-1:0]  head_raddr;
  logic [LINK_W-1:0]   head_rdata;
  logic                ent_we;
  logic [ENT_AW-1:0]   ent_waddr;
  entry_t              ent_wdata;
  logic [ENT_AW-1:0]   ent_raddr;
  logic [ENTRY_W-1:0]  ent_rdata_raw;
  entry_t              ent_rdata;

  // config port
  assign pready = 1'b1;
  assign prdata = 32'(active);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE) begin
      active <= pwdata[ACT_W-1:0];
    end
  end

  // buckets in use, saturated to 1..POINT_SLOTS
  always_comb begin
    priority if (active == '0) begin
      n = N_W'(1);
    end else if (32'(active) > POINT_SLOTS) begin
      n = N_W'(POINT_SLOTS);
    end else begin
      n = N_W'(active);
    end
  end

  assign in_tri  = (in_ch.kind == KIND_TRI);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  sfdt_canon u_canon (
    .is_tri (in_tri),
    .a      (in_ch.pt_a),
    .b      (in_ch.pt_b),
    .c      (in_ch.pt_c),
    .d      (in_ch.pt_d),
    .n      (n),
    .canon  (canon)
  );

  assign ent_rdata = entry_t'(ent_rdata_raw);
  assign used_full = used[ENT_AW];
  assign hit       = face_match(face_q, ent_rdata, tri_q);
  assign nb        = walk_bucket + N_W'(1);

  sfdt_ram #(.DEPTH(POINT_SLOTS), .WIDTH(LINK_W)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  sfdt_ram #(.DEPTH(ENTRY_SLOTS), .WIDTH(ENTRY_W)) u_entry (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ENTRY_W'(ent_wdata)),
    .raddr (ent_raddr),
    .rdata (ent_rdata_raw)
  );

  // memory port control
  always_comb begin
    head_we    = 1'b0;
    head_waddr = HEAD_AW'(face_q.p0);
    head_wdata = used;
    head_raddr = '0;
    ent_we     = 1'b0;
    ent_waddr  = used[ENT_AW-1:0];
    ent_wdata  = '{face: face_q, hidden: 1'b0, next: NO_LINK};
    ent_raddr  = cur[ENT_AW-1:0];
    unique case (state)
      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt;
        head_wdata = NO_LINK;
      end
      S_IDLE: begin
        head_raddr = (in_ch.kind == KIND_RESTART) ? '0 : HEAD_AW'(canon.face.p0);
      end
      S_HWAIT: begin
        ent_raddr = head_rdata[ENT_AW-1:0];
      end
      S_EWAIT: begin
        ent_raddr = ent_rdata.next[ENT_AW-1:0];
        if (hit) begin
          ent_we    = 1'b1;
          ent_waddr = cur[ENT_AW-1:0];
          ent_wdata = '{face: ent_rdata.face, hidden: 1'b1, next: ent_rdata.next};
        end
      end
      S_APPEND: begin
        ent_we  = !used_full;
        head_we = !used_full && last[ENT_AW];
      end
      S_LINK: begin
        ent_we    = 1'b1;
        ent_waddr = last[ENT_AW-1:0];
        ent_wdata = '{face: last_rec.face, hidden: last_rec.hidden, next: used};
      end
      S_FCHK: begin
        head_raddr = HEAD_AW'(nb);
      end
      S_RSWAIT, S_FHWAIT, S_FWAIT, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_cnt     <= '0;
      clr_emit    <= 1'b0;
      used        <= '0;
      walk_bucket <= '0;
      walk_entry  <= NO_LINK;
      out_valid   <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid && out_ch.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + HEAD_AW'(1);
          if (clr_cnt == HEAD_AW'(POINT_SLOTS - 1)) begin
            res_status <= ST_DONE;
            state      <= clr_emit ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            tri_q    <= in_tri;
            face_q   <= canon.face;
            res_face <= '0;
            unique case (in_ch.kind)
              KIND_CLEAR: begin
                used        <= '0;
                walk_bucket <= '0;
                walk_entry  <= NO_LINK;
                clr_cnt     <= '0;
                clr_emit    <= 1'b1;
                state       <= S_CLR;
              end
              KIND_QUAD, KIND_TRI: begin
                if (canon.bad) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else begin
                  state <= S_HWAIT;
                end
              end
              KIND_RESTART: begin
                state <= S_RSWAIT;
              end
              KIND_FETCH: begin
                cur   <= walk_entry;
                state <= S_FCHK;
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_HWAIT: begin
          cur  <= head_rdata;
          last <= NO_LINK;
          state <= head_rdata[ENT_AW] ? S_APPEND : S_EWAIT;
        end
        S_EWAIT: begin
          if (hit) begin
            res_status <= ST_MATCHED;
            state      <= S_FIN;
          end else begin
            last     <= cur;
            last_rec <= ent_rdata;
            cur      <= ent_rdata.next;
            // next entry is being read this cycle when the link is live
            if (ent_rdata.next[ENT_AW]) begin
              state <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          if (used_full) begin
            res_status <= ST_FULL;
            state      <= S_FIN;
          end else if (last[ENT_AW]) begin
            used       <= used + LINK_W'(1);
            res_status <= ST_INSERTED;
            state      <= S_FIN;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          used       <= used + LINK_W'(1);
          res_status <= ST_INSERTED;
          state      <= S_FIN;
        end
        S_RSWAIT: begin
          walk_bucket <= '0;
          walk_entry  <= head_rdata;
          res_status  <= ST_DONE;
          state       <= S_FIN;
        end
        S_FCHK: begin
          if (!cur[ENT_AW]) begin
            state <= S_FWAIT;
          end else if (walk_bucket >= n || nb >= n) begin
            walk_bucket <= n;
            walk_entry  <= NO_LINK;
            res_status  <= ST_END;
            state       <= S_FIN;
          end else begin
            walk_bucket <= nb;
            state       <= S_FHWAIT;
          end
        end
        S_FHWAIT: begin
          cur   <= head_rdata;
          state <= S_FCHK;
        end
        S_FWAIT: begin
          if (!ent_rdata.hidden) begin
            walk_entry <= ent_rdata.next;
            res_face   <= ent_rdata.face;
            res_status <= ST_FACE;
            state      <= S_FIN;
          end else begin
            cur   <= ent_rdata.next;
            state <= S_FCHK;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_face   <= res_face;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.status  = out_status;
  assign out_ch.face_p0 = out_face.p0;
  assign out_ch.face_p1 = out_face.p1;
  assign out_ch.face_p2 = out_face.p2;
  assign out_ch.face_p3 = out_face.p3;

`ifndef SYNTH
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    used <= LINK_W'(ENTRY_SLOTS))
    else $error("entry pool count past its size");

  a_face_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_FACE) |-> (out_face == '0))
    else $error("face fields set on a non-face result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ch.ready)
    else $error("second item taken before the first finished");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result loaded outside the finish step");
`endif

endmodule
